[sv/pidramp_pkg.sv]
// shared types and register indexes for the pid step with ramp limit
package pidramp_pkg;

    localparam int GainWidth  = 32;
    localparam int LimitWidth = 31;
    localparam int IndexWidth = 3;

    typedef enum logic [IndexWidth-1:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INTEG_GAIN = 3'd1,
        REG_DERIV_GAIN = 3'd2,
        REG_OUT_LIMIT  = 3'd3,
        REG_RAMP_STEP  = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic signed [GainWidth-1:0] prop_gain;
        logic signed [GainWidth-1:0] integ_gain_half_period;
        logic signed [GainWidth-1:0] deriv_gain_per_period;
        logic [LimitWidth-1:0]       output_limit;
        logic [LimitWidth-1:0]       ramp_step;
    } cfg_t;

endpackage

[sv/pidramp_regs.sv]
// configuration register file
module pidramp_regs (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pidramp_pkg::IndexWidth-1:0]     cfg_index,
    input  logic [pidramp_pkg::GainWidth-1:0]      cfg_data,
    output pidramp_pkg::cfg_t                      cfg
);

    pidramp_pkg::cfg_t cfg_reg;
    pidramp_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (pidramp_pkg::reg_index_t'(cfg_index))
                pidramp_pkg::REG_PROP_GAIN:  cfg_next.prop_gain = $signed(cfg_data);
                pidramp_pkg::REG_INTEG_GAIN: cfg_next.integ_gain_half_period = $signed(cfg_data);
                pidramp_pkg::REG_DERIV_GAIN: cfg_next.deriv_gain_per_period = $signed(cfg_data);
                pidramp_pkg::REG_OUT_LIMIT:
                    cfg_next.output_limit = cfg_data[pidramp_pkg::LimitWidth-1:0];
                pidramp_pkg::REG_RAMP_STEP:
                    cfg_next.ramp_step = cfg_data[pidramp_pkg::LimitWidth-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain              <= '0;
            cfg_reg.integ_gain_half_period <= '0;
            cfg_reg.deriv_gain_per_period  <= '0;
            cfg_reg.output_limit           <= '1;
            cfg_reg.ramp_step              <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[sv/pidramp_fmul.sv]
// fixed-point multiply, truncation toward zero and saturation
module pidramp_fmul #(
    parameter int AW            = 32,
    parameter int BW            = 33,
    parameter int DATA_WIDTH    = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic signed [AW-1:0]         a,
    input  logic signed [BW-1:0]         b,
    output logic signed [DATA_WIDTH-1:0] q
);

    localparam int PW = AW + BW;
    localparam logic signed [PW-1:0] MAXP =
        {{(PW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [PW-1:0] MINP = ~MAXP;
    localparam logic signed [PW-1:0] BIAS =
        {{(PW-FRACTION_BITS){1'b0}}, {FRACTION_BITS{1'b1}}};

    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] biased;
    logic signed [PW-1:0] shifted;

    always_comb
    begin
        prod    = PW'(a) * PW'(b);
        biased  = prod[PW-1] ? prod + BIAS : prod;
        shifted = biased >>> FRACTION_BITS;
        if (shifted > MAXP)
            q = MAXP[DATA_WIDTH-1:0];
        else if (shifted < MINP)
            q = MINP[DATA_WIDTH-1:0];
        else
            q = shifted[DATA_WIDTH-1:0];
    end

endmodule

[sv/pidramp_core.sv]
// pid datapath with integral, last error and last drive state
module pidramp_core #(
    parameter int DATA_WIDTH    = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  step,
    input  logic                                  clear,
    input  logic signed [pidramp_pkg::GainWidth-1:0] error_sample,
    input  pidramp_pkg::cfg_t                     cfg,
    output logic signed [DATA_WIDTH-1:0]          drive
);

    localparam int DW1 = DATA_WIDTH + 1;
    localparam int EW  = (DATA_WIDTH > pidramp_pkg::GainWidth ?
                          DATA_WIDTH : pidramp_pkg::GainWidth) + 3;
    localparam logic signed [EW-1:0] MAXE =
        {{(EW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [EW-1:0] MINE = ~MAXE;

    logic signed [DATA_WIDTH-1:0] integ_reg, integ_next;
    logic signed [DATA_WIDTH-1:0] last_err_reg, last_err_next;
    logic signed [DATA_WIDTH-1:0] last_drive_reg, last_drive_next;

    logic signed [EW-1:0]         e_wide;
    logic signed [DATA_WIDTH-1:0] e;
    logic signed [DW1-1:0]        e_sum;
    logic signed [DW1-1:0]        e_diff;
    logic signed [DATA_WIDTH-1:0] p_term;
    logic signed [DATA_WIDTH-1:0] i_incr;
    logic signed [DATA_WIDTH-1:0] d_term;
    logic signed [EW-1:0]         lim;
    logic signed [EW-1:0]         ramp;
    logic signed [EW-1:0]         integ_w;
    logic signed [EW-1:0]         y_w;
    logic signed [EW-1:0]         delta;
    logic signed [EW-1:0]         last_w;

    function automatic logic signed [EW-1:0] sat_w(input logic signed [EW-1:0] v);
        logic signed [EW-1:0] r;
        r = v;
        if (v > MAXE)
            r = MAXE;
        else if (v < MINE)
            r = MINE;
        return r;
    endfunction

    function automatic logic signed [EW-1:0] clamp_w(input logic signed [EW-1:0] v,
                                                     input logic signed [EW-1:0] l);
        logic signed [EW-1:0] r;
        r = v;
        if (v > l)
            r = l;
        else if (v < -l)
            r = -l;
        return r;
    endfunction

    always_comb
    begin
        e_wide = sat_w(EW'(error_sample));
        e      = e_wide[DATA_WIDTH-1:0];
        e_sum  = DW1'(e) + DW1'(last_err_reg);
        e_diff = DW1'(e) - DW1'(last_err_reg);
    end

    pidramp_fmul #(
        .AW(pidramp_pkg::GainWidth), .BW(DATA_WIDTH),
        .DATA_WIDTH(DATA_WIDTH), .FRACTION_BITS(FRACTION_BITS)
    ) u_p_mul (
        .a(cfg.prop_gain), .b(e), .q(p_term)
    );

    pidramp_fmul #(
        .AW(pidramp_pkg::GainWidth), .BW(DW1),
        .DATA_WIDTH(DATA_WIDTH), .FRACTION_BITS(FRACTION_BITS)
    ) u_i_mul (
        .a(cfg.integ_gain_half_period), .b(e_sum), .q(i_incr)
    );

    pidramp_fmul #(
        .AW(pidramp_pkg::GainWidth), .BW(DW1),
        .DATA_WIDTH(DATA_WIDTH), .FRACTION_BITS(FRACTION_BITS)
    ) u_d_mul (
        .a(cfg.deriv_gain_per_period), .b(e_diff), .q(d_term)
    );

    always_comb
    begin
        lim  = EW'($signed({1'b0, cfg.output_limit}));
        if (lim > MAXE)
            lim = MAXE;
        ramp    = EW'($signed({1'b0, cfg.ramp_step}));
        last_w  = EW'(last_drive_reg);
        integ_w = clamp_w(sat_w(EW'(integ_reg) + EW'(i_incr)), lim);
        y_w     = clamp_w(sat_w(EW'(p_term) + integ_w + EW'(d_term)), lim);
        delta   = y_w - last_w;
        if (ramp != '0)
        begin
            if (delta > ramp)
                y_w = sat_w(last_w + ramp);
            else if (delta < -ramp)
                y_w = sat_w(last_w - ramp);
        end

        if (clear)
        begin
            drive           = '0;
            integ_next      = '0;
            last_err_next   = '0;
            last_drive_next = '0;
        end
        else
        begin
            drive           = y_w[DATA_WIDTH-1:0];
            integ_next      = integ_w[DATA_WIDTH-1:0];
            last_err_next   = e;
            last_drive_next = y_w[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg      <= '0;
            last_err_reg   <= '0;
            last_drive_reg <= '0;
        end
        else if (step)
        begin
            integ_reg      <= integ_next;
            last_err_reg   <= last_err_next;
            last_drive_reg <= last_drive_next;
        end
    end

endmodule

[sv/pid_step_with_ramp_limit_top.sv]
// top level of the pid step with integral clamp and output ramp limit
//
// One error word in gives one drive word out. A word sits in an input register,
// passes the three multipliers, the clamps and the ramp limiter combinationally and
// lands in the output register, so the block takes a new word every cycle while
// the output side keeps up; output valid rises once the held input word advances.
// The rate is set by the update of the integral, last error and last drive
// registers, which each word reads and writes. Configuration writes are taken
// every cycle and should be made while no word is in flight.
module pid_step_with_ramp_limit_top #(
    parameter int DATA_WIDTH    = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [31:0]                         s_axis_tdata,  // error_sample
    input  logic                                s_axis_tuser,  // clear_state
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [31:0]                         m_axis_tdata,  // drive_value
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pidramp_pkg::IndexWidth-1:0]  cfg_index,
    input  logic [pidramp_pkg::GainWidth-1:0]   cfg_data
);

    pidramp_pkg::cfg_t cfg;

    logic                         in_valid_reg, in_valid_next;
    logic [31:0]                  in_error_reg;
    logic                         in_clear_reg;
    logic                         out_valid_reg, out_valid_next;
    logic [31:0]                  out_data_reg;
    logic                         advance;
    logic signed [DATA_WIDTH-1:0] drive;

    pidramp_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pidramp_core #(
        .DATA_WIDTH    (DATA_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .clear        (in_clear_reg),
        .error_sample ($signed(in_error_reg)),
        .cfg          (cfg),
        .drive        (drive)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready)
            in_valid_next = s_axis_tvalid;
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_error_reg <= s_axis_tdata;
            in_clear_reg <= s_axis_tuser;
        end
        if (advance)
            out_data_reg <= 32'(drive);
    end

endmodule
